FILE: sv/bubble_sort_ascending_defines.svh
// Assertion macros shared by the sorter modules.
`ifndef BUBBLE_SORT_ASCENDING_DEFINES_SVH
`define BUBBLE_SORT_ASCENDING_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

  localparam int DEPTH = 64;
  localparam int VAL_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [VAL_W-1:0] sample_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic store;
    logic mark_over;
    logic sort;
    logic odd;
    logic emit;
    logic clear;
  } bsa_cmd_t;

  typedef struct packed {
    logic   full;
    count_t count;
    logic   last_out;
  } bsa_status_t;

endpackage

`default_nettype wire

FILE: sv/bsa_ctrl.sv
`default_nettype none

module bsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tlast,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  bsa_pkg::bsa_status_t stat,
  output bsa_pkg::bsa_cmd_t    cmd
);
  import bsa_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SORT = 3'b010,
    S_EMIT = 3'b100
  } bsa_state_t;

  bsa_state_t state;
  bsa_state_t state_next;
  count_t     pass;
  count_t     pass_next;

  always_comb begin
    state_next = state;
    pass_next  = pass;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.store     = !stat.full;
          cmd.mark_over = stat.full;
          if (s_tlast) begin
            state_next = S_SORT;
            pass_next  = '0;
          end
        end
      end
      S_SORT: begin
        cmd.sort  = 1'b1;
        cmd.odd   = pass[0];
        pass_next = pass + count_t'(1);
        if (pass == stat.count - count_t'(1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          cmd.emit = 1'b1;
          if (stat.last_out) begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      pass  <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  `include "bubble_sort_ascending_defines.svh"

  `BSA_ASSERT_NEXT(a_sort_has_data, state == S_LOAD && state_next == S_SORT, stat.count != '0, "sort started with an empty set")
  `BSA_ASSERT_NOW(a_sort_passes, state == S_SORT, pass < stat.count, "sort pass count ran past the set size")
  `BSA_ASSERT_NEXT(a_emit_to_load, state == S_EMIT && cmd.clear, state == S_LOAD && stat.count == '0, "set not cleared after the final transaction")

endmodule

`default_nettype wire

FILE: sv/bsa_datapath.sv
`default_nettype none

module bsa_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  bsa_pkg::sample_t     in_value,
  input  bsa_pkg::bsa_cmd_t    cmd,
  output bsa_pkg::bsa_status_t stat,
  output bsa_pkg::sample_t     out_value,
  output logic                 out_over
);
  import bsa_pkg::*;

  sample_t          slot       [DEPTH];
  sample_t          slot_next  [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] valid_next;
  logic [DEPTH-2:0] swap;
  count_t           fill_count;
  logic             overflow_seen;

  for (genvar g = 0; g < DEPTH - 1; g++) begin : g_pair
    localparam logic PAR = logic'(g % 2);
    assign swap[g] = (PAR == cmd.odd) && valid[g+1] && (slot[g+1] < slot[g]);
  end

  always_comb begin
    slot_next  = slot;
    valid_next = valid;
    if (cmd.store) begin
      for (int i = DEPTH - 1; i > 0; i--) begin
        slot_next[i]  = slot[i-1];
        valid_next[i] = valid[i-1];
      end
      slot_next[0]  = in_value;
      valid_next[0] = 1'b1;
    end else if (cmd.sort) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (swap[i]) begin
          slot_next[i]   = slot[i+1];
          slot_next[i+1] = slot[i];
        end
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slot_next[i]  = slot[i+1];
        valid_next[i] = valid[i+1];
      end
      valid_next[DEPTH-1] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      valid <= valid_next;
      if (cmd.clear) begin
        fill_count    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (cmd.store) begin
          fill_count <= fill_count + count_t'(1);
        end
        if (cmd.mark_over) begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  assign stat.full     = (fill_count == count_t'(DEPTH));
  assign stat.count    = fill_count;
  assign stat.last_out = !valid[1];
  assign out_value     = slot[0];
  assign out_over      = overflow_seen;

  `include "bubble_sort_ascending_defines.svh"

  `BSA_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= count_t'(DEPTH), "fill count beyond capacity")
  `BSA_ASSERT_NOW(a_valid_packed, valid[1], valid[0], "stored values not packed at the bottom")
  `BSA_ASSERT_NEXT(a_emit_keeps, cmd.emit && valid[1], valid[0], "values lost while emitting")

endmodule

`default_nettype wire

FILE: sv/bubble_sort_ascending.sv
// Sorts sets of signed 32-bit values into ascending order.
// Input channel s_*: one value per transaction in s_tdata; s_tlast marks the
// final value of a set. Up to 64 values are kept; later values of the same set
// are dropped and every result of that set then carries m_tuser high.
// Output channel m_*: the set's values in ascending order, one per
// transaction, with m_tlast on the greatest value.
// Operation: while loading, s_tready is high and each value is taken as soon
// as s_tvalid is high. After the final value the set is sorted by alternating
// odd and even compare-exchange passes over the stored values, one pass per
// cycle and as many passes as values. Emission then gives one value per
// transaction. s_tready is low from the final input until the last result has
// been taken.
// While m_tready is low the current result holds and the sorter waits.
// A synchronous reset empties the store and returns to loading.
`default_nettype none

module bubble_sort_ascending (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,
  output logic [0:0]  m_tuser    // [0] overflowed
);
  import bsa_pkg::*;

  bsa_cmd_t    cmd;
  bsa_status_t stat;
  sample_t     out_value;
  logic        out_over;

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_value  (sample_t'(s_tdata)),
    .cmd       (cmd),
    .stat      (stat),
    .out_value (out_value),
    .out_over  (out_over)
  );

  assign m_tdata    = 32'(out_value);
  assign m_tlast    = stat.last_out;
  assign m_tuser[0] = out_over;

endmodule

`default_nettype wire
